### src/tpcs_pkg.sv
package tpcs_pkg;

    localparam int COORD_BITS = 12;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * COORD_BITS + 2;
    localparam int WGT_W      = 2 * COORD_BITS + 3;
    localparam int WU_W       = 2 * COORD_BITS + 1;
    localparam int NUM_W      = WU_W + 8;
    localparam int QUOT_BITS  = 8;

    // Vertex colors are 0x40 everywhere except the vertex's own channel at 0xFF.
    // Since the three weights add up to the area, each channel is
    // 0x40 + floor(0xBF * w / area).
    localparam logic [7:0] COLOR_BASE = 8'h40;
    localparam logic [7:0] COLOR_GAIN = 8'hFF - 8'h40;

    localparam int QDEPTH = 4;
    localparam int ODEPTH = 16;

    typedef logic [2:0] t_cfg_idx;
    localparam t_cfg_idx REG_V0_X = 3'd0;
    localparam t_cfg_idx REG_V0_Y = 3'd1;
    localparam t_cfg_idx REG_V1_X = 3'd2;
    localparam t_cfg_idx REG_V1_Y = 3'd3;
    localparam t_cfg_idx REG_V2_X = 3'd4;
    localparam t_cfg_idx REG_V2_Y = 3'd5;

    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
    } t_pixel;

    typedef struct packed {
        logic       covered;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_result;

    typedef struct packed {
        logic                       covered;
        logic [2:0][WU_W-1:0]       w;
    } t_work;

endpackage

### src/tpcs_fifo.sv
module tpcs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [PW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_cnt;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        bump = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= bump(r_wr);
            if (i_pop)  r_rd <= bump(r_rd);
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_data;
    end

    assign o_data  = r_mem[r_rd];
    assign o_empty = (r_cnt == '0);
endmodule

### src/tpcs_front.sv
module tpcs_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  tpcs_pkg::t_cfg_idx        i_cfg_idx,
    input  logic [tpcs_pkg::COORD_BITS-1:0] i_cfg_data,
    input  logic                      i_valid,
    input  tpcs_pkg::t_pixel          i_pixel,
    output logic                      o_valid,
    output tpcs_pkg::t_work           o_work,
    output logic [tpcs_pkg::WU_W-1:0] o_area_abs
);
    import tpcs_pkg::*;

    logic [COORD_BITS-1:0] r_vx [0:2];
    logic [COORD_BITS-1:0] r_vy [0:2];

    logic signed [PROD_W-1:0] r_ap, r_aq;
    logic signed [WGT_W-1:0]  r_area;
    logic                     r_area_neg, r_area_zero;
    logic [WU_W-1:0]          r_area_abs;

    logic                     r_va, r_vb;
    logic signed [PROD_W-1:0] r_pa [0:2];
    logic signed [PROD_W-1:0] r_pb [0:2];
    t_work                    r_work;

    logic signed [PROD_W-1:0] n_pa [0:2];
    logic signed [PROD_W-1:0] n_pb [0:2];
    t_work                    n_work;

    function automatic logic signed [DIFF_W-1:0] sdiff(
        input logic [COORD_BITS-1:0] a,
        input logic [COORD_BITS-1:0] b);
        sdiff = signed'({1'b0, a}) - signed'({1'b0, b});
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_vx[k] <= '0;
                r_vy[k] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_V0_X: r_vx[0] <= i_cfg_data;
                REG_V0_Y: r_vy[0] <= i_cfg_data;
                REG_V1_X: r_vx[1] <= i_cfg_data;
                REG_V1_Y: r_vy[1] <= i_cfg_data;
                REG_V2_X: r_vx[2] <= i_cfg_data;
                REG_V2_Y: r_vy[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Area tracks the vertex registers, registered through r_ap/r_aq, r_area, then r_area_neg/r_area_zero/r_area_abs.
    always_ff @(posedge i_clk) begin
        r_ap        <= sdiff(r_vx[1], r_vx[0]) * sdiff(r_vy[2], r_vy[0]);
        r_aq        <= sdiff(r_vy[1], r_vy[0]) * sdiff(r_vx[2], r_vx[0]);
        r_area      <= WGT_W'(r_ap) - WGT_W'(r_aq);
        r_area_neg  <= r_area[WGT_W-1];
        r_area_zero <= (r_area == '0);
        r_area_abs  <= r_area[WGT_W-1] ? WU_W'(-r_area) : WU_W'(r_area);
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_pa[k] = sdiff(r_vx[(k+2)%3], r_vx[(k+1)%3])
                    * sdiff(i_pixel.pixel_y, r_vy[(k+1)%3]);
            n_pb[k] = sdiff(r_vy[(k+2)%3], r_vy[(k+1)%3])
                    * sdiff(i_pixel.pixel_x, r_vx[(k+1)%3]);
        end
    end

    always_comb begin
        logic signed [WGT_W-1:0] w;
        logic                    hit;
        hit = !r_area_zero;
        for (int k = 0; k < 3; k++) begin
            w = WGT_W'(r_pa[k]) - WGT_W'(r_pb[k]);
            if (r_area_neg) w = -w;
            if (w[WGT_W-1]) hit = 1'b0;
            n_work.w[k] = WU_W'(w);
        end
        n_work.covered = hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            r_va <= i_valid;
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pa   <= n_pa;
        r_pb   <= n_pb;
        r_work <= n_work;
    end

    assign o_valid    = r_vb;
    assign o_work     = r_work;
    assign o_area_abs = r_area_abs;
endmodule

### src/tpcs_back.sv
module tpcs_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  tpcs_pkg::t_work           i_work,
    input  logic [tpcs_pkg::WU_W-1:0] i_area_abs,
    output logic                      o_valid,
    output tpcs_pkg::t_result         o_result
);
    import tpcs_pkg::*;

    typedef struct packed {
        logic                              covered;
        logic [2:0][NUM_W-1:0]             rem;
        logic [2:0][QUOT_BITS-1:0]         quo;
    } t_div_stage;

    logic       r_vld [0:QUOT_BITS];
    t_div_stage r_stg [0:QUOT_BITS];
    t_div_stage n_stg [1:QUOT_BITS];

    // One quotient bit per stage, most significant first.
    always_comb begin
        logic [NUM_W-1:0] dsh;
        for (int s = 1; s <= QUOT_BITS; s++) begin
            n_stg[s] = r_stg[s-1];
            dsh = NUM_W'(i_area_abs) << (QUOT_BITS - s);
            for (int k = 0; k < 3; k++) begin
                if (r_stg[s-1].rem[k] >= dsh) begin
                    n_stg[s].rem[k] = r_stg[s-1].rem[k] - dsh;
                    n_stg[s].quo[k][QUOT_BITS-s] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= QUOT_BITS; s++) r_vld[s] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
            for (int s = 1; s <= QUOT_BITS; s++) r_vld[s] <= r_vld[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_stg[0].covered <= i_work.covered;
        for (int k = 0; k < 3; k++) begin
            r_stg[0].rem[k] <= NUM_W'(i_work.w[k]) * NUM_W'(COLOR_GAIN);
            r_stg[0].quo[k] <= '0;
        end
        for (int s = 1; s <= QUOT_BITS; s++) r_stg[s] <= n_stg[s];
    end

    always_comb begin
        o_result.covered = r_stg[QUOT_BITS].covered;
        o_result.red     = '0;
        o_result.green   = '0;
        o_result.blue    = '0;
        if (r_stg[QUOT_BITS].covered) begin
            o_result.red   = COLOR_BASE + r_stg[QUOT_BITS].quo[0];
            o_result.green = COLOR_BASE + r_stg[QUOT_BITS].quo[1];
            o_result.blue  = COLOR_BASE + r_stg[QUOT_BITS].quo[2];
        end
    end

    assign o_valid = r_vld[QUOT_BITS];
endmodule

### src/triangle_pixel_coverage_shader.sv
// Triangle pixel coverage and Gouraud color blend.
// Configuration: write i_cfg_data into register i_cfg_idx (vertex0 x/y,
// vertex1 x/y, vertex2 x/y, indexes 0..5) while i_cfg_we is high; write only
// while the block is idle, and allow a few cycles before the next item.
// Input: a pixel coordinate is taken at a clock edge with push high and full
// low. Output: the oldest result sits on o_result while empty is low and
// leaves at an edge with pop high.
// Throughput: one item per cycle while full is low; the front runs a multiply
// stage and a classify stage, the back runs one scaling stage and an 8-stage
// restoring divider (one quotient bit per stage), with a 4-entry queue between
// them and a 16-entry output queue behind the divider.
// When the receiver stops popping, credits stop the back from draining the
// middle queue once the output queue is spoken for, and full rises when the
// middle queue plus the front stages hold four items; nothing is dropped.
// Reset clears vertices to zero and empties both queues.
module triangle_pixel_coverage_shader (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  tpcs_pkg::t_cfg_idx              i_cfg_idx,
    input  logic [tpcs_pkg::COORD_BITS-1:0] i_cfg_data,
    input  logic                            push,
    output logic                            full,
    input  tpcs_pkg::t_pixel                i_pixel,
    output logic                            empty,
    input  logic                            pop,
    output tpcs_pkg::t_result               o_result
);
    import tpcs_pkg::*;

    localparam int FCW = $clog2(QDEPTH + 1);
    localparam int BCW = $clog2(ODEPTH + 1);

    logic            accept, q_pop, o_pop, q_empty;
    logic            f_valid, b_valid;
    t_work           f_work, q_work;
    logic [WU_W-1:0] area_abs;
    t_result         b_result;
    logic [FCW-1:0]  r_fcred;
    logic [BCW-1:0]  r_bcred;

    assign full   = (r_fcred == FCW'(QDEPTH));
    assign accept = push && !full;
    assign q_pop  = !q_empty && (r_bcred < BCW'(ODEPTH));
    assign o_pop  = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fcred <= '0;
            r_bcred <= '0;
        end else begin
            r_fcred <= r_fcred + FCW'(accept) - FCW'(q_pop);
            r_bcred <= r_bcred + BCW'(q_pop) - BCW'(o_pop);
        end
    end

    tpcs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (accept),
        .i_pixel    (i_pixel),
        .o_valid    (f_valid),
        .o_work     (f_work),
        .o_area_abs (area_abs)
    );

    tpcs_fifo #(.WIDTH($bits(t_work)), .DEPTH(QDEPTH)) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  (f_work),
        .i_pop   (q_pop),
        .o_data  (q_work),
        .o_empty (q_empty)
    );

    tpcs_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (q_pop),
        .i_work     (q_work),
        .i_area_abs (area_abs),
        .o_valid    (b_valid),
        .o_result   (b_result)
    );

    tpcs_fifo #(.WIDTH($bits(t_result)), .DEPTH(ODEPTH)) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (b_valid),
        .i_data  (b_result),
        .i_pop   (o_pop),
        .o_data  (o_result),
        .o_empty (empty)
    );
endmodule

### tb/tb_triangle_pixel_coverage_shader.sv
`timescale 1ns / 100ps

module tb_triangle_pixel_coverage_shader;
    import tpcs_pkg::*;

    localparam int LATENCY     = 12;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int N_RANDOM    = 1500;

    // Expected shaded pixels, oldest first, computed from the vertex registers.
    class shade_scoreboard;
        logic [COORD_BITS-1:0] vtx[6];
        t_result pending[$];
        int errors;
        int hits;
        int n_checked;

        function void set_reg(t_cfg_idx idx, logic [COORD_BITS-1:0] val);
            if (idx <= REG_V2_Y) begin
                vtx[idx] = val;
            end
        endfunction

        function longint edge_w(longint ax, longint ay, longint bx, longint by,
                                longint px, longint py);
            return (bx - ax) * (py - ay) - (by - ay) * (px - ax);
        endfunction

        function logic [7:0] blend(longint w0, longint w1, longint w2, longint area,
                                   logic [7:0] c0, logic [7:0] c1, logic [7:0] c2);
            longint v;
            v = (w0 * c0 + w1 * c1 + w2 * c2) / area;
            return (v > 255) ? 8'hFF : v[7:0];
        endfunction

        function void note_pixel(t_pixel px);
            longint x0, y0, x1, y1, x2, y2, qx, qy, area, w0, w1, w2;
            t_result r;
            x0 = vtx[REG_V0_X]; y0 = vtx[REG_V0_Y];
            x1 = vtx[REG_V1_X]; y1 = vtx[REG_V1_Y];
            x2 = vtx[REG_V2_X]; y2 = vtx[REG_V2_Y];
            qx = px.pixel_x; qy = px.pixel_y;
            area = edge_w(x0, y0, x1, y1, x2, y2);
            w0 = edge_w(x1, y1, x2, y2, qx, qy);
            w1 = edge_w(x2, y2, x0, y0, qx, qy);
            w2 = edge_w(x0, y0, x1, y1, qx, qy);
            r = '0;
            if (area < 0) begin
                area = -area; w0 = -w0; w1 = -w1; w2 = -w2;
            end
            if (area != 0 && w0 >= 0 && w1 >= 0 && w2 >= 0) begin
                r.covered = 1'b1;
                r.red   = blend(w0, w1, w2, area, 8'hFF, 8'h40, 8'h40);
                r.green = blend(w0, w1, w2, area, 8'h40, 8'hFF, 8'h40);
                r.blue  = blend(w0, w1, w2, area, 8'h40, 8'h40, 8'hFF);
                hits++;
            end
            pending.push_back(r);
        endfunction

        function void check_result(t_result got);
            t_result exp_r;
            n_checked++;
            if (pending.size() == 0) begin
                $error("unexpected result %h", got);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.covered !== exp_r.covered) begin
                $error("covered: expected %0d actual %0d", exp_r.covered, got.covered);
                errors++;
            end
            if (got.red !== exp_r.red) begin
                $error("red: expected %0d actual %0d", exp_r.red, got.red);
                errors++;
            end
            if (got.green !== exp_r.green) begin
                $error("green: expected %0d actual %0d", exp_r.green, got.green);
                errors++;
            end
            if (got.blue !== exp_r.blue) begin
                $error("blue: expected %0d actual %0d", exp_r.blue, got.blue);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    t_cfg_idx              i_cfg_idx;
    logic [COORD_BITS-1:0] i_cfg_data;
    logic                  push;
    logic                  full;
    t_pixel                i_pixel;
    logic                  empty;
    logic                  pop;
    t_result               o_result;

    shade_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    longint cycles;
    int n_pixels;

    triangle_pixel_coverage_shader DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .push       (push),
        .full       (full),
        .i_pixel    (i_pixel),
        .empty      (empty),
        .pop        (pop),
        .o_result   (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycles);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Receiver: pop decided at the falling edge, result taken at the rising edge.
    initial begin
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            sb.check_result(o_result);
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [COORD_BITS-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        sb.set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_triangle(int x0, int y0, int x1, int y1, int x2, int y2);
        write_reg(REG_V0_X, x0[COORD_BITS-1:0]);
        write_reg(REG_V0_Y, y0[COORD_BITS-1:0]);
        write_reg(REG_V1_X, x1[COORD_BITS-1:0]);
        write_reg(REG_V1_Y, y1[COORD_BITS-1:0]);
        write_reg(REG_V2_X, x2[COORD_BITS-1:0]);
        write_reg(REG_V2_Y, y2[COORD_BITS-1:0]);
        repeat (4) @(negedge i_clk);
    endtask

    // Hold push until the item is taken; called at a falling edge.
    task automatic send_pixel(int x, int y);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push    <= 1'b1;
        i_pixel <= '{pixel_x: x[COORD_BITS-1:0], pixel_y: y[COORD_BITS-1:0]};
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sb.note_pixel('{pixel_x: x[COORD_BITS-1:0], pixel_y: y[COORD_BITS-1:0]});
        n_pixels++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        push <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    function automatic int near_coord(int c);
        int v;
        v = c + $signed($urandom_range(600)) - 300;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return v;
    endfunction

    task automatic random_phase(int n_items, int sendp, int recvp);
        int vx[3], vy[3], cx, cy;
        send_idle_pct  = sendp;
        recv_stall_pct = recvp;
        for (int k = 0; k < n_items; k++) begin
            // new triangle every so often, mostly small so pixels land inside
            if (k % 60 == 0) begin
                drain();
                cx = $urandom_range(4095);
                cy = $urandom_range(4095);
                for (int j = 0; j < 3; j++) begin
                    if ($urandom_range(9) == 0) begin
                        vx[j] = $urandom_range(4095); vy[j] = $urandom_range(4095);
                    end else begin
                        vx[j] = near_coord(cx); vy[j] = near_coord(cy);
                    end
                end
                set_triangle(vx[0], vy[0], vx[1], vy[1], vx[2], vy[2]);
            end
            case ($urandom_range(9))
                0: send_pixel($urandom_range(4095), $urandom_range(4095));
                1: send_pixel(vx[$urandom_range(2)], vy[$urandom_range(2)]);
                default: begin
                    int a, b, s;
                    // random convex mix of the vertices, rounded down to the grid
                    a = $urandom_range(1000);
                    b = $urandom_range(1000 - a);
                    s = 1000 - a - b;
                    send_pixel((a * vx[0] + b * vx[1] + s * vx[2]) / 1000,
                               (a * vy[0] + b * vy[1] + s * vy[2]) / 1000);
                end
            endcase
        end
        drain();
    endtask

    initial begin
        sb = new();
        for (int j = 0; j < 6; j++) sb.vtx[j] = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        n_pixels   = 0;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = REG_V0_X;
        i_cfg_data = '0;
        push       = 1'b0;
        i_pixel    = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        // reset vertices: degenerate, nothing covered
        send_pixel(0, 0);
        send_pixel(4095, 4095);
        drain();
        // half-screen triangle, counter-clockwise, then the other winding
        set_triangle(0, 0, 4095, 0, 0, 4095);
        send_pixel(0, 0);
        send_pixel(4095, 0);
        send_pixel(0, 4095);
        send_pixel(2047, 2048);
        send_pixel(2048, 2048);
        send_pixel(4095, 4095);
        send_pixel(1000, 1000);
        drain();
        set_triangle(0, 0, 0, 4095, 4095, 0);
        send_pixel(0, 0);
        send_pixel(1365, 1365);
        send_pixel(4095, 4095);
        send_pixel(2047, 0);
        drain();
        // collinear vertices: zero area
        set_triangle(10, 10, 20, 20, 4095, 4095);
        send_pixel(15, 15);
        send_pixel(10, 10);
        drain();
        // small triangle at the far corner, all-ones and alternating-bit pixels
        set_triangle(4095, 4095, 4093, 4095, 4095, 4093);
        send_pixel(4095, 4095);
        send_pixel(4094, 4094);
        send_pixel(4093, 4093);
        send_pixel(2730, 1365);
        drain();
        // out-of-range index is ignored by the block
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= 3'd7;
        i_cfg_data <= '1;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        send_pixel(4095, 4095);
        drain();

        random_phase(400, 0, 0);
        random_phase(400, 76, 0);
        random_phase(400, 0, 76);
        random_phase(300, 9, 9);

        $display("shaded %0d pixels, %0d covered, over both windings and degenerate cases",
                 n_pixels, sb.hits);
        $display("checked %0d results under mixed push/pop throttling", sb.n_checked);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
